>>> rtl/core/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types, constants and helpers for the matrix keypad scanner.
// ----------------------------------------------------------------------------
package kpd_pkg;

    // Matrix geometry
    localparam int NUM_ROWS = 4;
    localparam int NUM_COLS = 3;
    localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

    // Field widths
    localparam int COLS_W  = 3;
    localparam int CNT_W   = 16;
    localparam int CODE_W  = 4;
    localparam int DRIVE_W = 4;
    localparam int CIDX_W  = 2;

    // Only the sampled column bits that exist in the matrix count
    localparam logic [COLS_W-1:0] COL_MASK =
        (NUM_COLS >= COLS_W) ? {COLS_W{1'b1}} : COLS_W'((1 << NUM_COLS) - 1);

    // Configuration register indexes
    localparam logic CFG_BOUNCE = 1'b0;
    localparam logic CFG_HOLD   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0] BOUNCE_RST = CNT_W'(20);
    localparam logic [CNT_W-1:0] HOLD_RST   = CNT_W'(200);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BOUNCE = 2'd1,
        PH_HOLD   = 2'd2
    } t_phase;

    // One result of a scan tick
    typedef struct packed {
        logic               key_valid;
        logic [CODE_W-1:0]  key_num;
        logic [DRIVE_W-1:0] row_drive;
    } t_kpd_result;

    // One-hot drive of a row; rows beyond the drive width read as zero
    function automatic logic [DRIVE_W-1:0] row_onehot(input logic [ROW_W-1:0] row);
        logic [DRIVE_W-1:0] drv;
        drv = '0;
        for (int r = 0; r < DRIVE_W; r++) begin
            if (32'(row) == r) begin
                drv[r] = 1'b1;
            end
        end
        return drv;
    endfunction

endpackage

>>> rtl/core/matrix_keypad_scanner_core.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_core
// Stream wrapper of the keypad scanner: input register, tracker, result
// register and configuration registers.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one scan tick carrying the sampled
// column lines; every tick yields exactly one result with the released-key
// flag, the key number and the row drive to apply next. The block takes one
// tick per clock unless the master side stalls: the whole tick update is a
// single pass of logic between the input register and the result register,
// so a tick is presented on the master side once it has passed both; a new
// tick is accepted into an empty input register while a result waits. The
// user must write the bounce and hold window lengths through the configuration
// channel only while no tick is in flight; the block does not enforce this.
module matrix_keypad_scanner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] column_lines, [7:3] zero
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] key_num, [7:4] row_drive
    output logic        m_axis_tuser,   // [0] key_valid
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import kpd_pkg::*;

    logic                r_in_valid;
    logic [COLS_W-1:0]   r_in_cols;
    logic                r_out_valid;
    t_kpd_result         r_out;
    logic [CNT_W-1:0]    r_bounce_ticks;
    logic [CNT_W-1:0]    r_hold_ticks;
    logic                w_out_free;
    logic                w_step;
    t_kpd_result         w_result;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign o_cfg_ready   = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounce_ticks <= BOUNCE_RST;
            r_hold_ticks   <= HOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BOUNCE: r_bounce_ticks <= i_cfg_data;
                CFG_HOLD:   r_hold_ticks   <= i_cfg_data;
                default:    r_hold_ticks   <= r_hold_ticks;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cols <= s_axis_tdata[COLS_W-1:0];
        end
    end

    kpd_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_step),
        .i_cols         (r_in_cols),
        .i_bounce_ticks (r_bounce_ticks),
        .i_hold_ticks   (r_hold_ticks),
        .o_result       (w_result)
    );

    // Result register; hold while the master side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.row_drive, r_out.key_num};
    assign m_axis_tuser  = r_out.key_valid;

endmodule

>>> rtl/core/kpd_engine.sv
// ----------------------------------------------------------------------------
// kpd_engine
// Press tracking state and the per-tick update: detect, debounce, hold
// checks, release report and row stepping.
// ----------------------------------------------------------------------------
module kpd_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [kpd_pkg::COLS_W-1:0] i_cols,
    input  logic [kpd_pkg::CNT_W-1:0]  i_bounce_ticks,
    input  logic [kpd_pkg::CNT_W-1:0]  i_hold_ticks,
    output kpd_pkg::t_kpd_result       o_result
);
    import kpd_pkg::*;

    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_cnt,   n_cnt;
    logic [ROW_W-1:0]    r_row,   n_row;
    logic [CODE_W-1:0]   r_key,   n_key;
    logic                w_report;
    logic [COLS_W-1:0]   w_cols;
    logic [CIDX_W-1:0]   w_col_idx;
    logic [7:0]          w_code_full;

    assign w_cols = i_cols & COL_MASK;

    // Pick the lowest pressed column
    always_comb begin
        w_col_idx = CIDX_W'(COLS_W);
        for (int c = COLS_W - 1; c >= 0; c--) begin
            if (w_cols[c]) begin
                w_col_idx = CIDX_W'(c);
            end
        end
    end

    assign w_code_full = 8'(r_row) * 8'(NUM_COLS) + 8'(w_col_idx);

    // Next state of the press tracker
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_key    = r_key;
        w_report = 1'b0;

        case (r_phase)
            PH_BOUNCE, PH_HOLD: n_phase = r_phase;
            default:            n_phase = PH_IDLE;
        endcase

        // Latch a new press
        if (n_phase == PH_IDLE && w_cols != '0) begin
            n_key   = w_code_full[CODE_W-1:0];
            n_phase = PH_BOUNCE;
            n_cnt   = i_bounce_ticks;
        end

        // Count down the bounce window
        if (n_phase == PH_BOUNCE) begin
            if (n_cnt != '0) begin
                n_cnt = n_cnt - CNT_W'(1);
            end else begin
                n_phase = PH_HOLD;
                n_cnt   = i_hold_ticks;
            end
        end

        // Check for release at the end of each hold window
        if (n_phase == PH_HOLD) begin
            if (n_cnt != '0) begin
                n_cnt = n_cnt - CNT_W'(1);
            end else if (w_cols == '0) begin
                n_phase  = PH_IDLE;
                w_report = 1'b1;
            end else begin
                n_cnt = i_hold_ticks;
            end
        end

        // Step the row drive unless a key is reported
        n_row = r_row;
        if (!w_report) begin
            if (32'(r_row) == NUM_ROWS - 1) begin
                n_row = '0;
            end else begin
                n_row = r_row + ROW_W'(1);
            end
        end
    end

    // Result of this tick; a key latched in this same tick is not reported in it
    always_comb begin
        o_result.key_valid = w_report;
        o_result.key_num   = w_report ? n_key : '0;
        o_result.row_drive = row_onehot(n_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_row   <= '0;
            r_key   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_key   <= n_key;
        end
    end

    // A reported key always leaves the tracker idle
    a_report_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && w_report) |=> (r_phase == PH_IDLE))
        else $error("tracker not idle after report");

    // The row stays put on a report tick
    a_report_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && w_report) |=> (r_row == $past(r_row)))
        else $error("row moved on report");

    // The row steps by one on a tick without a report
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !w_report && (32'(r_row) != NUM_ROWS - 1))
            |=> (r_row == ROW_W'($past(r_row) + ROW_W'(1))))
        else $error("row did not advance");

    // Without a tick the tracker holds
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_row) && $stable(r_phase) && $stable(r_cnt)))
        else $error("state changed without a tick");

endmodule

>>> tb/matrix_keypad_scanner_core_tb.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_core_tb
// Drives scan ticks into the keypad scanner and checks every result against
// a tracker that mirrors the press, bounce and hold behavior. Ticks come as
// directed presses first, then as random press and release sequences under
// several bounce and hold windows. Both stream sides stall at random, with
// one long receiver hold-off and pauses for the configuration writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_keypad_scanner_core_tb;
    import kpd_pkg::*;

    localparam int STALL_PCT  = 29;
    localparam int HOLD_OFF   = 40;
    localparam int IDLE_LIMIT = 2000;

    // Tracks the scanner state and keeps the results still owed by the block
    class key_report_sb;
        logic [CNT_W-1:0]  bounce_win;
        logic [CNT_W-1:0]  hold_win;
        t_phase            phase;
        logic [CNT_W-1:0]  countdown;
        logic [ROW_W-1:0]  scan_row;
        logic [CODE_W-1:0] held_key;
        t_kpd_result       owed_q[$];
        int                errors;

        function new();
            bounce_win = BOUNCE_RST;
            hold_win   = HOLD_RST;
            phase      = PH_IDLE;
            countdown  = '0;
            scan_row   = '0;
            held_key   = '0;
            errors     = 0;
        endfunction

        function void write_reg(input logic idx, input logic [CNT_W-1:0] val);
            if (idx == CFG_BOUNCE) begin
                bounce_win = val;
            end else begin
                hold_win = val;
            end
        endfunction

        // Advance the tracker by one scan tick and queue its result
        function void note_tick(input logic [COLS_W-1:0] raw);
            logic [COLS_W-1:0] cols;
            int                col;
            logic              report;
            t_kpd_result       res;
            cols   = raw & COL_MASK;
            report = 1'b0;
            col    = COLS_W;
            if (phase == PH_IDLE && cols != '0) begin
                for (int c = COLS_W - 1; c >= 0; c--) begin
                    if (cols[c]) begin
                        col = c;
                    end
                end
                held_key  = CODE_W'(int'(scan_row) * NUM_COLS + col);
                phase     = PH_BOUNCE;
                countdown = bounce_win;
            end
            if (phase == PH_BOUNCE) begin
                if (countdown != '0) begin
                    countdown = countdown - 1'b1;
                end else begin
                    phase     = PH_HOLD;
                    countdown = hold_win;
                end
            end
            // Release check at the end of each hold window
            if (phase == PH_HOLD) begin
                if (countdown != '0) begin
                    countdown = countdown - 1'b1;
                end else if (cols == '0) begin
                    phase  = PH_IDLE;
                    report = 1'b1;
                end else begin
                    countdown = hold_win;
                end
            end
            if (!report) begin
                scan_row = ROW_W'((int'(scan_row) + 1) % NUM_ROWS);
            end
            res.key_valid = report;
            res.key_num   = report ? held_key : '0;
            if (int'(scan_row) < DRIVE_W) begin
                res.row_drive = DRIVE_W'(1) << scan_row;
            end else begin
                res.row_drive = '0;
            end
            owed_q.push_back(res);
        endfunction

        function void check_result(input t_kpd_result got);
            t_kpd_result want;
            if (owed_q.size() == 0) begin
                $error("unexpected result: valid %0d key %0d drive %b",
                       got.key_valid, got.key_num, got.row_drive);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.key_valid !== want.key_valid) begin
                $error("key_valid: expected %0d, got %0d", want.key_valid, got.key_valid);
                errors++;
            end
            if (got.key_num !== want.key_num) begin
                $error("key_num: expected %0d, got %0d", want.key_num, got.key_num);
                errors++;
            end
            if (got.row_drive !== want.row_drive) begin
                $error("row_drive: expected %b, got %b", want.row_drive, got.row_drive);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    key_report_sb sb = new();
    bit           steady_flow = 1'b0;
    bit           rx_hold_off = 1'b0;
    int           tick_count  = 0;
    int           idle_cycles = 0;

    matrix_keypad_scanner_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Observe every handshake and feed the tracker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_tick(s_axis_tdata[COLS_W-1:0]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result({m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[7:4]});
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            if (rx_hold_off) begin
                m_axis_tready <= 1'b0;
                rx_hold_off = 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end else begin
                m_axis_tready <= steady_flow || ($urandom_range(99) >= STALL_PCT);
                @(posedge i_clk);
            end
        end
    end

    // Offer one tick, idling at random first, and hold it until accepted
    task automatic send_tick(input logic [COLS_W-1:0] cols);
        while (!steady_flow && $urandom_range(99) < STALL_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, cols};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tick_count++;
    endtask

    // Stop sending and let every owed result come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both window lengths back to back while the block is empty
    task automatic set_windows(input logic [15:0] bounce, input logic [15:0] hold);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_BOUNCE;
        i_cfg_data  <= bounce;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_HOLD;
        i_cfg_data  <= hold;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One press and release with random column content, or a burst of noise
    task automatic run_press(input int bounce, input int hold);
        int                n;
        logic [COLS_W-1:0] c;
        if ($urandom_range(5) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) send_tick(COLS_W'($urandom_range(7)));
        end else begin
            n = $urandom_range(0, 3);
            repeat (n) send_tick('0);
            n = 1 + $urandom_range(0, bounce + hold + 2);
            repeat (n) begin
                c = COLS_W'($urandom_range(1, 7));
                // drop the contact now and then
                if ($urandom_range(7) == 0) begin
                    c = '0;
                end
                send_tick(c);
            end
            repeat (bounce + hold + 2) send_tick('0);
        end
    endtask

    initial begin
        int bounce;
        int hold;
        int target;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_BOUNCE;
        i_cfg_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset windows: a press only starts the bounce count
        send_tick(3'b000);
        send_tick(3'b000);
        send_tick(3'b100);
        send_tick(3'b111);
        send_tick(3'b000);

        // Zero windows: press, hold and release check in the press tick
        set_windows(16'd0, 16'd0);
        send_tick(3'b001);
        send_tick(3'b000);
        send_tick(3'b010);
        send_tick(3'b010);
        send_tick(3'b000);
        send_tick(3'b110);
        send_tick(3'b000);
        send_tick(3'b100);
        send_tick(3'b000);
        send_tick(3'b101);

        // Short windows: bounce end enters hold, held key reloads the count
        set_windows(16'd1, 16'd2);
        send_tick(3'b011);
        send_tick(3'b011);
        send_tick(3'b010);
        send_tick(3'b010);
        send_tick(3'b000);
        send_tick(3'b000);
        send_tick(3'b000);
        send_tick(3'b000);

        // Random presses under a series of window settings
        for (int p = 0; p < 7; p++) begin
            bounce = $urandom_range(0, 4);
            hold   = $urandom_range(0, 5);
            set_windows(16'(bounce), 16'(hold));
            steady_flow = (p == 2);
            if (p == 4) begin
                rx_hold_off = 1'b1;
            end
            target = tick_count + 70;
            while (tick_count < target) run_press(bounce, hold);
        end
        steady_flow = 1'b0;

        // Widest windows: the press never leaves the bounce count
        set_windows(16'hFFFF, 16'hFFFF);
        send_tick(3'b111);
        repeat (8) send_tick(COLS_W'($urandom_range(7)));

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/kpd_pkg.sv
rtl/core/kpd_engine.sv
rtl/core/matrix_keypad_scanner_core.sv
tb/matrix_keypad_scanner_core_tb.sv
